// ----- rtl/core/assert_macros.svh -----
// Assertion macros shared by the clamp RTL.
// Needs nothing else; included by files that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is held low
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is held low
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/core/ocfc_pkg.sv -----
// Constants and types for the octagon coupled force clamp.
// No dependencies; imported by ocfc_res_if and the top level.
package ocfc_pkg;

    localparam int LIMIT_W    = 23;
    localparam int RADIUS_W   = 12;
    localparam int CFG_DATA_W = 23;
    localparam int CFG_ADDR_W = 1;
    localparam int SCALE_W    = 17;
    localparam int Q_FRAC     = 16;
    // 2*f_max in Q16 force units always fits here
    localparam int BOUND_W    = 40;
    // quotient bits of the coupling divider resolved per stage
    localparam int D1_STEP    = 2;
    localparam int GAIN_W     = 9;

    localparam logic [SCALE_W-1:0]  ONE_Q16         = 17'h10000;
    localparam logic [15:0]         HALF_SQRT2_Q16  = 16'd46341;
    // |Mz|/(2R) with R in mm: 1000/2 per unit moment
    localparam logic [GAIN_W-1:0]   COUPLING_GAIN   = 9'd500;
    localparam logic [LIMIT_W-1:0]  FORCE_LIMIT_RST = 23'd25600;
    localparam logic [RADIUS_W-1:0] RADIUS_RST      = 12'd250;

    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_FORCE_LIMIT    = 1'b0,
        CFG_CHASSIS_RADIUS = 1'b1
    } t_cfg_reg;

endpackage

// ----- rtl/core/ocfc_channels.sv -----
// Valid/ready channel interfaces for the clamp: command in, result out.
// Depends on ocfc_pkg for the scale width.
interface ocfc_cmd_if #(
    parameter int FORCE_BITS = 24
);
    logic                         valid;
    logic                         ready;
    logic signed [FORCE_BITS-1:0] force_x;
    logic signed [FORCE_BITS-1:0] force_y;
    logic signed [FORCE_BITS-1:0] moment_z;

    modport source (output valid, output force_x, output force_y, output moment_z,
                    input ready);
    modport sink   (input valid, input force_x, input force_y, input moment_z,
                    output ready);
endinterface

interface ocfc_res_if
    import ocfc_pkg::*;
#(
    parameter int FORCE_BITS = 24
);
    logic                         valid;
    logic                         ready;
    logic signed [FORCE_BITS-1:0] clamped_x;
    logic signed [FORCE_BITS-1:0] clamped_y;
    logic signed [FORCE_BITS-1:0] moment_out;
    logic        [SCALE_W-1:0]    scale_factor;
    logic                         was_clipped;

    modport source (output valid, output clamped_x, output clamped_y, output moment_out,
                    output scale_factor, output was_clipped, input ready);
    modport sink   (input valid, input clamped_x, input clamped_y, input moment_out,
                    input scale_factor, input was_clipped, output ready);
endinterface

// ----- rtl/core/octagon_coupled_force_clamp.sv -----
// Octagon coupled force clamp: pipelined force/moment limiter, top level.
// Depends on ocfc_pkg, ocfc_channels.sv (ocfc_cmd_if, ocfc_res_if), assert_macros.svh.
//
//   channel   dir   handshake           payload
//   i_cmd     in    valid / ready       force_x, force_y, moment_z
//   o_res     out   valid / ready       clamped_x, clamped_y, moment_out,
//                                       scale_factor, was_clipped
//   i_cfg     in    i_cfg_we only       i_cfg_addr, i_cfg_data
//
// One beat accepted per cycle while no beat is parked in the holding register.
// The pipeline holds the coupling divider (20 stages, two quotient bits each) and the
// scale divider (16 stages, one bit each) plus seven stages of setup and scaling.
// Reset clears the stage valid bits and loads force_limit 25600 and radius 250.
// On an output stall one more beat is parked in a holding register, then the whole
// pipeline freezes and i_cmd.ready drops until the held beat is taken.
`include "assert_macros.svh"

module octagon_coupled_force_clamp
    import ocfc_pkg::*;
#(
    parameter int FORCE_BITS = 24
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_ADDR_W-1:0] i_cfg_addr,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    ocfc_cmd_if.sink              i_cmd,
    ocfc_res_if.source            o_res
);

    localparam int FB       = FORCE_BITS;
    localparam int PW       = FB + Q_FRAC;
    localparam int WIDE     = (PW > BOUND_W) ? PW : BOUND_W;
    localparam int HI_SPLIT = BOUND_W - Q_FRAC;
    localparam int MXW      = (FB + GAIN_W - 1 > HI_SPLIT + RADIUS_W + 1)
                              ? FB + GAIN_W - 1 : HI_SPLIT + RADIUS_W + 1;
    localparam int HW       = MXW - HI_SPLIT;
    localparam int PRW      = FB + SCALE_W + 1;
    localparam int D1_STG   = BOUND_W / D1_STEP;

    localparam int S_ABS    = 1;
    localparam int S_MULT   = 2;
    localparam int S_SETUP  = 3;
    localparam int S_D1     = 4;
    localparam int S_ALLOW  = S_D1 + D1_STG;
    localparam int S_TRIG   = S_ALLOW + 1;
    localparam int S_D2     = S_TRIG + 1;
    localparam int S_MUL    = S_D2 + Q_FRAC;
    localparam int S_OUT    = S_MUL + 1;
    localparam int NSTG     = S_OUT + 1;
    localparam int LAST     = NSTG - 1;

    typedef struct packed {
        logic signed [FB-1:0]   fx;
        logic signed [FB-1:0]   fy;
        logic signed [FB-1:0]   mz;
        logic [FB-1:0]          amz;
        logic [FB:0]            asum;
        logic [FB:0]            adif;
        logic [PW-1:0]          ax;
        logic [PW-1:0]          ay;
        logic [PW-1:0]          pu;
        logic [PW-1:0]          pw;
        logic [PW-1:0]          pmax;
        logic [MXW-1:0]         mag;
        logic                   ovf;
        logic [RADIUS_W-1:0]    rem1;
        logic [BOUND_W-1:0]     ncq;
        logic [WIDE-1:0]        aplus;
        logic                   trig;
        logic [PW-1:0]          rem2;
        logic [Q_FRAC-1:0]      q2;
        logic [SCALE_W-1:0]     scale;
        logic signed [PRW-1:0]  px;
        logic signed [PRW-1:0]  py;
        logic signed [FB-1:0]   cx;
        logic signed [FB-1:0]   cy;
    } t_stage;

    logic [LIMIT_W-1:0]  r_force_limit;
    logic [RADIUS_W-1:0] r_radius;
    logic [RADIUS_W-1:0] radius_eff;

    t_stage              r_stage [NSTG];
    t_stage              n_stage [NSTG];
    logic [NSTG-1:0]     r_vld;
    t_stage              r_hold;
    logic                r_hold_vld;
    logic                adv;

    function automatic t_stage stage_step(input t_stage x, input int s,
                                          input logic [RADIUS_W-1:0] rdiv,
                                          input logic [LIMIT_W-1:0]  flim);
        t_stage                y;
        logic [BOUND_W-1:0]    bound;
        logic signed [FB:0]    sum;
        logic signed [FB:0]    dif;
        logic [FB-1:0]         absfx;
        logic [FB-1:0]         absfy;
        logic [PW:0]           uprod;
        logic [PW:0]           wprod;
        logic [HW-1:0]         hi;
        logic [PW-1:0]         m1;
        logic [PW-1:0]         m2;
        logic [RADIUS_W:0]     t13;
        logic [PW:0]           t2;
        logic                  ge;
        logic signed [SCALE_W:0] sc;
        logic signed [PRW-1:0] bias_x;
        logic signed [PRW-1:0] bias_y;
        logic signed [PRW-1:0] tx;
        logic signed [PRW-1:0] ty;
        y     = x;
        bound = BOUND_W'(flim) << (BOUND_W - LIMIT_W);
        if (s == S_ABS) begin
            sum    = {x.fx[FB-1], x.fx} + {x.fy[FB-1], x.fy};
            dif    = {x.fx[FB-1], x.fx} - {x.fy[FB-1], x.fy};
            y.asum = sum[FB] ? (FB+1)'(-sum) : (FB+1)'(sum);
            y.adif = dif[FB] ? (FB+1)'(-dif) : (FB+1)'(dif);
            y.amz  = x.mz[FB-1] ? FB'(-x.mz) : FB'(x.mz);
            absfx  = x.fx[FB-1] ? FB'(-x.fx) : FB'(x.fx);
            absfy  = x.fy[FB-1] ? FB'(-x.fy) : FB'(x.fy);
            y.ax   = {absfx, {Q_FRAC{1'b0}}};
            y.ay   = {absfy, {Q_FRAC{1'b0}}};
        end else if (s == S_MULT) begin
            // diagonal projections are sqrt(2)/2 * |Fx +- Fy|
            y.mag = MXW'(x.amz) * MXW'(COUPLING_GAIN);
            uprod = (PW+1)'(x.asum) * (PW+1)'(HALF_SQRT2_Q16);
            wprod = (PW+1)'(x.adif) * (PW+1)'(HALF_SQRT2_Q16);
            y.pu  = uprod[PW-1:0];
            y.pw  = wprod[PW-1:0];
        end else if (s == S_SETUP) begin
            // the octagon is symmetric, so the largest projection is the largest magnitude
            m1     = (x.ax > x.ay) ? x.ax : x.ay;
            m2     = (x.pu > x.pw) ? x.pu : x.pw;
            y.pmax = (m1 > m2) ? m1 : m2;
            // coupling at or above 2^40 always exceeds the bound: flag and saturate
            hi     = x.mag[MXW-1:HI_SPLIT];
            y.ovf  = (|hi[HW-1:RADIUS_W]) || (hi[RADIUS_W-1:0] >= rdiv);
            y.rem1 = hi[RADIUS_W-1:0];
            y.ncq  = {x.mag[HI_SPLIT-1:0], {Q_FRAC{1'b0}}};
        end else if (s >= S_D1 && s < S_ALLOW) begin
            // restoring division by the radius; quotient shifts in behind the numerator
            for (int k = 0; k < D1_STEP; k++) begin
                t13    = {y.rem1, y.ncq[BOUND_W-1]};
                ge     = t13 >= {1'b0, rdiv};
                y.rem1 = ge ? RADIUS_W'(t13 - {1'b0, rdiv}) : t13[RADIUS_W-1:0];
                y.ncq  = {y.ncq[BOUND_W-2:0], ge};
            end
        end else if (s == S_ALLOW) begin
            // non-positive allowance collapses to zero, giving a zero scale on trigger
            y.aplus = (x.ovf || (x.ncq >= bound)) ? '0 : WIDE'(bound - x.ncq);
        end else if (s == S_TRIG) begin
            y.trig = WIDE'(x.pmax) > x.aplus;
            y.rem2 = x.aplus[PW-1:0];
            y.q2   = '0;
        end else if (s >= S_D2 && s < S_MUL) begin
            t2     = {x.rem2, 1'b0};
            ge     = t2 >= {1'b0, x.pmax};
            y.rem2 = ge ? PW'(t2 - {1'b0, x.pmax}) : t2[PW-1:0];
            y.q2   = {x.q2[Q_FRAC-2:0], ge};
        end else if (s == S_MUL) begin
            y.scale = x.trig ? {1'b0, x.q2} : ONE_Q16;
            sc      = {1'b0, y.scale};
            y.px    = PRW'(x.fx) * PRW'(sc);
            y.py    = PRW'(x.fy) * PRW'(sc);
        end else begin
            // truncate toward zero: bias negative products before the shift
            bias_x = x.px[PRW-1] ? PRW'((1 << Q_FRAC) - 1) : '0;
            bias_y = x.py[PRW-1] ? PRW'((1 << Q_FRAC) - 1) : '0;
            tx     = (x.px + bias_x) >>> Q_FRAC;
            ty     = (x.py + bias_y) >>> Q_FRAC;
            y.cx   = tx[FB-1:0];
            y.cy   = ty[FB-1:0];
        end
        return y;
    endfunction

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_force_limit <= FORCE_LIMIT_RST;
            r_radius      <= RADIUS_RST;
        end else if (i_cfg_we) begin
            case (t_cfg_reg'(i_cfg_addr))
                CFG_FORCE_LIMIT:    r_force_limit <= i_cfg_data[LIMIT_W-1:0];
                CFG_CHASSIS_RADIUS: r_radius      <= i_cfg_data[RADIUS_W-1:0];
                default: ;
            endcase
        end
    end

    // a zero radius divides as one
    assign radius_eff = (r_radius == '0) ? RADIUS_W'(1) : r_radius;

    // freeze everything while a beat is parked in the holding register
    assign adv = !r_hold_vld;

    always_comb begin
        n_stage[0]    = '0;
        n_stage[0].fx = i_cmd.force_x;
        n_stage[0].fy = i_cmd.force_y;
        n_stage[0].mz = i_cmd.moment_z;
        for (int s = 1; s < NSTG; s++) begin
            n_stage[s] = stage_step(r_stage[s-1], s, radius_eff, r_force_limit);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld      <= '0;
            r_hold_vld <= 1'b0;
        end else begin
            if (adv) begin
                r_vld <= {r_vld[NSTG-2:0], i_cmd.valid};
            end
            if (r_hold_vld) begin
                if (o_res.ready) begin
                    r_hold_vld <= 1'b0;
                end
            end else if (r_vld[LAST] && !o_res.ready) begin
                r_hold_vld <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_stage <= n_stage;
        end
        if (!r_hold_vld && r_vld[LAST] && !o_res.ready) begin
            r_hold <= r_stage[LAST];
        end
    end

    assign i_cmd.ready        = adv;
    assign o_res.valid        = r_hold_vld || r_vld[LAST];
    assign o_res.clamped_x    = r_hold_vld ? r_hold.cx    : r_stage[LAST].cx;
    assign o_res.clamped_y    = r_hold_vld ? r_hold.cy    : r_stage[LAST].cy;
    assign o_res.moment_out   = r_hold_vld ? r_hold.mz    : r_stage[LAST].mz;
    assign o_res.scale_factor = r_hold_vld ? r_hold.scale : r_stage[LAST].scale;
    assign o_res.was_clipped  = ~o_res.scale_factor[SCALE_W-1];

    `ASSERT_IMPLIES(a_zero_scale_zero_force, i_clk, i_rst_n,
        o_res.valid && (o_res.scale_factor == '0),
        (o_res.clamped_x == '0) && (o_res.clamped_y == '0),
        "zero scale produced a nonzero force")
    `ASSERT_IMPLIES(a_unclipped_passthrough, i_clk, i_rst_n,
        r_vld[LAST] && !r_stage[LAST].trig,
        (r_stage[LAST].cx == r_stage[LAST].fx) && (r_stage[LAST].cy == r_stage[LAST].fy),
        "unclipped force changed on its way through")
    `ASSERT_IMPLIES(a_scale_in_range, i_clk, i_rst_n,
        o_res.valid,
        (o_res.scale_factor <= ONE_Q16) && (o_res.was_clipped == (o_res.scale_factor != ONE_Q16)),
        "scale out of range or clip flag inconsistent")
    `ASSERT_NEXT(a_hold_freezes_pipe, i_clk, i_rst_n,
        r_hold_vld,
        $stable(r_vld),
        "pipeline moved while a beat was parked")

endmodule
